// ===== rtl/core/aar_pkg.sv =====
package aar_pkg;

	// Fixed-point constants, Q.20 radians
	localparam int ZW = 26;
	localparam int CW = 24;
	localparam logic signed [ZW-1:0] PI_Q20      = 26'sd3294199;
	localparam logic signed [ZW-1:0] TWO_PI_Q20  = 26'sd6588397;
	localparam logic signed [ZW-1:0] HALF_PI_Q20 = 26'sd1647099;
	localparam logic signed [CW-1:0] GAIN_Q20    = 24'sd636751;
	localparam logic signed [CW-1:0] ONE_Q20     = 24'sd1048576;
	localparam int ATAN_LEN = 24;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} aar_in_t;

	typedef struct packed {
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m13;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic signed [15:0] m23;
		logic signed [15:0] m31;
		logic signed [15:0] m32;
		logic signed [15:0] m33;
	} aar_out_t;

	// Opcodes
	localparam logic [1:0] OP_ROT_X    = 2'd0;
	localparam logic [1:0] OP_ROT_Y    = 2'd1;
	localparam logic [1:0] OP_ROT_Z    = 2'd2;
	localparam logic [1:0] OP_ROT_AXIS = 2'd3;

	// Arctangent of 2^-i in Q.20
	function automatic logic signed [CW-1:0] atan_q20(input int i);
		logic signed [CW-1:0] a;
		begin
			case (i)
				0: a = 24'sd823550;
				1: a = 24'sd486170;
				2: a = 24'sd256879;
				3: a = 24'sd130396;
				4: a = 24'sd65451;
				5: a = 24'sd32757;
				6: a = 24'sd16383;
				7: a = 24'sd8192;
				8: a = 24'sd4096;
				9: a = 24'sd2048;
				10: a = 24'sd1024;
				11: a = 24'sd512;
				12: a = 24'sd256;
				13: a = 24'sd128;
				14: a = 24'sd64;
				15: a = 24'sd32;
				16: a = 24'sd16;
				17: a = 24'sd8;
				18: a = 24'sd4;
				19: a = 24'sd2;
				20: a = 24'sd1;
				default: a = 24'sd0;
			endcase
			return a;
		end
	endfunction

	// Q.46 to Q2.13: round half up, saturate
	function automatic logic signed [15:0] rnd_sat(input logic signed [59:0] v);
		logic signed [59:0] r;
		logic signed [15:0] o;
		begin
			r = (v + 60'sd4294967296) >>> 33;
			if (r > 60'sd32767)
				o = 16'sh7fff;
			else if (r < -60'sd32768)
				o = 16'sh8000;
			else
				o = r[15:0];
			return o;
		end
	endfunction

endpackage

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
// Axis-angle to 3x3 rotation matrix.
// Command channel: drive item with start high; the transaction is taken at
// any rising edge where start is high and busy is low. busy stays low, so a
// new transaction may be issued in every cycle.
// opcode picks rotation about x, y, z or about (axis_x, axis_y, axis_z).
// Angle is Q3.12 radians, axis and matrix entries are Q2.13, saturated.
// Result channel: done is high for one cycle with the nine entries on result.
// Throughput is one per cycle. The pipeline has two range-reduction stages,
// one stage per CORDIC iteration and three multiply/sum stages.
// The receiver cannot stall: results leave in issue order, one per done.
// Reset clears all valid bits; transactions in flight are dropped.
module axis_angle_rotation_matrix #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  aar_pkg::aar_in_t   item,
	output logic               done,
	output aar_pkg::aar_out_t  result
);

	localparam int ZW = aar_pkg::ZW;
	localparam int CW = aar_pkg::CW;

	assign busy = 1'b0;

	// Stage 1: scale to Q.20 and wrap into [-pi, pi]
	logic                    v_s1;
	aar_pkg::aar_in_t        it_s1;
	logic signed [ZW-1:0]    z_s1;
	logic signed [ZW-1:0]    z_in;

	always_comb begin
		z_in = ZW'($signed(item.angle)) <<< 8;
		if (z_in > aar_pkg::PI_Q20)
			z_in = z_in - aar_pkg::TWO_PI_Q20;
		else if (z_in < -aar_pkg::PI_Q20)
			z_in = z_in + aar_pkg::TWO_PI_Q20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		it_s1 <= item;
		z_s1  <= z_in;
	end

	// Stage 2: fold into [-pi/2, pi/2]
	logic                    v_s2;
	aar_pkg::aar_in_t        it_s2;
	logic signed [CW-1:0]    z_s2;
	logic                    neg_s2;
	logic signed [ZW-1:0]    z_fold;
	logic                    neg_fold;

	always_comb begin
		z_fold   = z_s1;
		neg_fold = 1'b0;
		if (z_s1 > aar_pkg::HALF_PI_Q20) begin
			z_fold   = z_s1 - aar_pkg::PI_Q20;
			neg_fold = 1'b1;
		end else if (z_s1 < -aar_pkg::HALF_PI_Q20) begin
			z_fold   = z_s1 + aar_pkg::PI_Q20;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		it_s2  <= it_s1;
		z_s2   <= z_fold[CW-1:0];
		neg_s2 <= neg_fold;
	end

	// Stage 3: one CORDIC iteration per register stage
	logic                  v_s3   [0:CORDIC_STEPS];
	aar_pkg::aar_in_t      it_s3  [0:CORDIC_STEPS];
	logic                  neg_s3 [0:CORDIC_STEPS];
	logic signed [CW-1:0]  x_s3   [0:CORDIC_STEPS];
	logic signed [CW-1:0]  y_s3   [0:CORDIC_STEPS];
	logic signed [CW-1:0]  z_s3   [0:CORDIC_STEPS];

	assign v_s3[0]   = v_s2;
	assign it_s3[0]  = it_s2;
	assign neg_s3[0] = neg_s2;
	assign x_s3[0]   = aar_pkg::GAIN_Q20;
	assign y_s3[0]   = '0;
	assign z_s3[0]   = z_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] xs, ys;
		assign xs = x_s3[i] >>> i;
		assign ys = y_s3[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s3[i+1] <= 1'b0;
			else
				v_s3[i+1] <= v_s3[i];
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			it_s3[i+1]  <= it_s3[i];
			neg_s3[i+1] <= neg_s3[i];
			if (!z_s3[i][CW-1]) begin
				x_s3[i+1] <= x_s3[i] - ys;
				y_s3[i+1] <= y_s3[i] + xs;
				z_s3[i+1] <= z_s3[i] - aar_pkg::atan_q20(i);
			end else begin
				x_s3[i+1] <= x_s3[i] + ys;
				y_s3[i+1] <= y_s3[i] - xs;
				z_s3[i+1] <= z_s3[i] + aar_pkg::atan_q20(i);
			end
		end
	end

	// Stage 4: apply fold sign, form 1-c and axis outer products
	logic                  v_s4;
	logic [1:0]            op_s4;
	logic signed [15:0]    ux_s4, uy_s4, uz_s4;
	logic signed [CW-1:0]  c_s4, s_s4, t_s4;
	logic signed [31:0]    xx_s4, xy_s4, xz_s4, yy_s4, yz_s4, zz_s4;
	logic signed [CW-1:0]  c_fin, s_fin;
	aar_pkg::aar_in_t      it_end;

	assign it_end = it_s3[CORDIC_STEPS];
	assign c_fin  = neg_s3[CORDIC_STEPS] ? -x_s3[CORDIC_STEPS] : x_s3[CORDIC_STEPS];
	assign s_fin  = neg_s3[CORDIC_STEPS] ? -y_s3[CORDIC_STEPS] : y_s3[CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		op_s4 <= it_end.opcode;
		ux_s4 <= it_end.axis_x;
		uy_s4 <= it_end.axis_y;
		uz_s4 <= it_end.axis_z;
		c_s4  <= c_fin;
		s_s4  <= s_fin;
		t_s4  <= aar_pkg::ONE_Q20 - c_fin;
		xx_s4 <= $signed(it_end.axis_x) * $signed(it_end.axis_x);
		xy_s4 <= $signed(it_end.axis_x) * $signed(it_end.axis_y);
		xz_s4 <= $signed(it_end.axis_x) * $signed(it_end.axis_z);
		yy_s4 <= $signed(it_end.axis_y) * $signed(it_end.axis_y);
		yz_s4 <= $signed(it_end.axis_y) * $signed(it_end.axis_z);
		zz_s4 <= $signed(it_end.axis_z) * $signed(it_end.axis_z);
	end

	// Stage 5: sine times axis, (1-c) times outer products
	logic                  v_s5;
	logic [1:0]            op_s5;
	logic signed [CW-1:0]  c_s5, s_s5;
	logic signed [39:0]    sx_s5, sy_s5, sz_s5;
	logic signed [55:0]    txx_s5, txy_s5, txz_s5, tyy_s5, tyz_s5, tzz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		op_s5  <= op_s4;
		c_s5   <= c_s4;
		s_s5   <= s_s4;
		sx_s5  <= 40'(s_s4) * 40'(ux_s4);
		sy_s5  <= 40'(s_s4) * 40'(uy_s4);
		sz_s5  <= 40'(s_s4) * 40'(uz_s4);
		txx_s5 <= 56'(t_s4) * 56'(xx_s4);
		txy_s5 <= 56'(t_s4) * 56'(xy_s4);
		txz_s5 <= 56'(t_s4) * 56'(xz_s4);
		tyy_s5 <= 56'(t_s4) * 56'(yy_s4);
		tyz_s5 <= 56'(t_s4) * 56'(yz_s4);
		tzz_s5 <= 56'(t_s4) * 56'(zz_s4);
	end

	// Stage 6: select Q.46 entries, round, saturate and present the result
	logic signed [59:0] m [0:8];
	logic signed [59:0] c46, s46, one46, sx46, sy46, sz46;

	always_comb begin
		c46   = 60'(c_s5) <<< 26;
		s46   = 60'(s_s5) <<< 26;
		one46 = 60'sd1 <<< 46;
		sx46  = 60'(sx_s5) <<< 13;
		sy46  = 60'(sy_s5) <<< 13;
		sz46  = 60'(sz_s5) <<< 13;
		for (int k = 0; k < 9; k++)
			m[k] = '0;
		case (op_s5)
			aar_pkg::OP_ROT_X: begin
				m[0] = one46;
				m[4] = c46;  m[5] = -s46;
				m[7] = s46;  m[8] = c46;
			end
			aar_pkg::OP_ROT_Y: begin
				m[0] = c46;  m[2] = s46;
				m[4] = one46;
				m[6] = -s46; m[8] = c46;
			end
			aar_pkg::OP_ROT_Z: begin
				m[0] = c46;  m[1] = -s46;
				m[3] = s46;  m[4] = c46;
				m[8] = one46;
			end
			default: begin
				m[0] = c46 + 60'(txx_s5);
				m[1] = -sz46 + 60'(txy_s5);
				m[2] = sy46 + 60'(txz_s5);
				m[3] = sz46 + 60'(txy_s5);
				m[4] = c46 + 60'(tyy_s5);
				m[5] = -sx46 + 60'(tyz_s5);
				m[6] = -sy46 + 60'(txz_s5);
				m[7] = sx46 + 60'(tyz_s5);
				m[8] = c46 + 60'(tzz_s5);
			end
		endcase
	end

	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v_s5;
	end

	always_ff @(posedge clk) begin
		op_q       <= op_s5;
		result.m11 <= aar_pkg::rnd_sat(m[0]);
		result.m12 <= aar_pkg::rnd_sat(m[1]);
		result.m13 <= aar_pkg::rnd_sat(m[2]);
		result.m21 <= aar_pkg::rnd_sat(m[3]);
		result.m22 <= aar_pkg::rnd_sat(m[4]);
		result.m23 <= aar_pkg::rnd_sat(m[5]);
		result.m31 <= aar_pkg::rnd_sat(m[6]);
		result.m32 <= aar_pkg::rnd_sat(m[7]);
		result.m33 <= aar_pkg::rnd_sat(m[8]);
	end

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(CORDIC_STEPS + 5) done)
		else $error("result strobe missing after fixed latency");

	a_rot_x_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == aar_pkg::OP_ROT_X) |->
		(result.m11 == 16'sd8192 && result.m12 == 16'sd0 && result.m21 == 16'sd0))
		else $error("rotation about x has wrong fixed entries");

	a_rot_z_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == aar_pkg::OP_ROT_Z) |->
		(result.m33 == 16'sd8192 && result.m13 == 16'sd0 && result.m32 == 16'sd0))
		else $error("rotation about z has wrong fixed entries");
`endif

endmodule

// ===== dv/axis_angle_rotation_matrix_checker.sv =====
module axis_angle_rotation_matrix_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  aar_pkg::aar_in_t  item,
	input  logic              done,
	input  aar_pkg::aar_out_t result,
	output int                n_errors,
	output int                n_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 14;

	aar_pkg::aar_out_t matrix_q[$];

	// round half up a Q.46 value to Q2.13, then clamp
	function automatic logic signed [15:0] q46_to_q13(input longint v);
		longint r;
		begin
			r = (v + (64'sd1 <<< 32)) >>> 33;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[15:0];
		end
	endfunction

	// sine and cosine in Q.20 by rotation-mode CORDIC
	function automatic void cordic_sincos(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint z, x, y, xs, ys;
		bit flip;
		int i;
		begin
			z = longint'(ang) * 256;
			x = 636751;
			y = 0;
			flip = 0;
			if (z > 3294199) z -= 6588397;
			else if (z < -3294199) z += 6588397;
			if (z > 1647099) begin
				z -= 3294199;
				flip = 1;
			end else if (z < -1647099) begin
				z += 3294199;
				flip = 1;
			end
			for (i = 0; i < STEPS && i < aar_pkg::ATAN_LEN; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= longint'(aar_pkg::atan_q20(i));
				end else begin
					x += ys; y -= xs; z += longint'(aar_pkg::atan_q20(i));
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		end
	endfunction

	// expected matrix for one command
	function automatic aar_pkg::aar_out_t rotation_matrix(input aar_pkg::aar_in_t cmd);
		longint s, c, c46, s46, one, ux, uy, uz, t, sx, sy, sz;
		longint m[9];
		aar_pkg::aar_out_t o;
		begin
			cordic_sincos(cmd.angle, s, c);
			one = 64'sd1 <<< 46;
			c46 = c * (64'sd1 <<< 26);
			s46 = s * (64'sd1 <<< 26);
			foreach (m[k]) m[k] = 0;
			case (cmd.opcode)
				aar_pkg::OP_ROT_X: begin
					m[0] = one; m[4] = c46; m[5] = -s46; m[7] = s46; m[8] = c46;
				end
				aar_pkg::OP_ROT_Y: begin
					m[0] = c46; m[2] = s46; m[4] = one; m[6] = -s46; m[8] = c46;
				end
				aar_pkg::OP_ROT_Z: begin
					m[0] = c46; m[1] = -s46; m[3] = s46; m[4] = c46; m[8] = one;
				end
				default: begin
					ux = cmd.axis_x; uy = cmd.axis_y; uz = cmd.axis_z;
					t = 1048576 - c;
					sx = s * ux * 8192; sy = s * uy * 8192; sz = s * uz * 8192;
					m[0] = c46 + t * ux * ux;
					m[1] = -sz + t * ux * uy;
					m[2] = sy + t * ux * uz;
					m[3] = sz + t * ux * uy;
					m[4] = c46 + t * uy * uy;
					m[5] = -sx + t * uy * uz;
					m[6] = -sy + t * ux * uz;
					m[7] = sx + t * uy * uz;
					m[8] = c46 + t * uz * uz;
				end
			endcase
			o.m11 = q46_to_q13(m[0]); o.m12 = q46_to_q13(m[1]);
			o.m13 = q46_to_q13(m[2]); o.m21 = q46_to_q13(m[3]);
			o.m22 = q46_to_q13(m[4]); o.m23 = q46_to_q13(m[5]);
			o.m31 = q46_to_q13(m[6]); o.m32 = q46_to_q13(m[7]);
			o.m33 = q46_to_q13(m[8]);
			return o;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		begin
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
			n_errors++;
		end
	endtask

	task automatic check_entry(input string nm, input logic signed [15:0] got,
			input logic signed [15:0] want);
		begin
			if (got !== want) report_mismatch(nm, got, want);
		end
	endtask

	initial n_errors = 0;
	assign n_pending = matrix_q.size();

	// predict on command transactions, compare on result transactions
	always @(posedge clk) begin
		aar_pkg::aar_out_t want;
		if (arst_n) begin
			if (done) begin
				if (matrix_q.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					want = matrix_q.pop_front();
					check_entry("m11", result.m11, want.m11);
					check_entry("m12", result.m12, want.m12);
					check_entry("m13", result.m13, want.m13);
					check_entry("m21", result.m21, want.m21);
					check_entry("m22", result.m22, want.m22);
					check_entry("m23", result.m23, want.m23);
					check_entry("m31", result.m31, want.m31);
					check_entry("m32", result.m32, want.m32);
					check_entry("m33", result.m33, want.m33);
				end
			end
			if (start && !busy)
				matrix_q.push_back(rotation_matrix(item));
		end
	end
endmodule

// ===== dv/axis_angle_rotation_matrix_test.sv =====
module axis_angle_rotation_matrix_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 2000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	aar_pkg::aar_in_t  item;
	logic              done;
	aar_pkg::aar_out_t result;
	int                n_errors;
	int                n_pending;
	int                idle_cycles;

	axis_angle_rotation_matrix u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	axis_angle_rotation_matrix_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .n_errors(n_errors), .n_pending(n_pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog: count cycles with no transaction on either side
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("axis_angle_rotation_matrix_test: done, errors");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd8192;
			3: return -16'sd8192;
			4: return 16'(int'($urandom_range(0, 16384)) - 8192);
			default: return 16'($urandom());
		endcase
	endfunction

	// issue one command transaction, then with gaps set hold start low for a random gap, which may be zero
	task automatic send_cmd(input logic [1:0] op, input logic signed [15:0] ang,
			input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] az, input bit gaps);
		int gap;
		begin
			start <= 1'b1;
			item <= '{opcode: op, angle: ang, axis_x: ax, axis_y: ay, axis_z: az};
			@(posedge clk);
			while (busy) @(posedge clk);
			gap = 0;
			if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
					: $urandom_range(0, 2);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic signed [15:0] angs[8];
		int blk;
		bit gaps;
		angs = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd6434, -16'sd6434, 16'sd12868,
			-16'sd12868, 16'sd25736};
		arst_n = 0;
		start = 0;
		item = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: rotations about x, y and z at extreme and quadrant angles
		for (int i = 0; i < 4; i++) begin
			send_cmd(aar_pkg::OP_ROT_X, angs[2*i], 16'sd0, 16'sd0, 16'sd0, 1'b0);
			send_cmd(aar_pkg::OP_ROT_Y, angs[2*i+1], 16'sd0, 16'sd0, 16'sd0, 1'b0);
			send_cmd(aar_pkg::OP_ROT_Z, angs[2*i], 16'sd0, 16'sd0, 16'sd0, 1'b0);
		end
		// given axis: unit, non-unit and saturating components
		send_cmd(aar_pkg::OP_ROT_AXIS, 16'sd6434, 16'sd8192, 16'sd0, 16'sd0, 1'b1);
		send_cmd(aar_pkg::OP_ROT_AXIS, 16'sd3217, 16'sd0, 16'sd0, 16'sd8192, 1'b1);
		send_cmd(aar_pkg::OP_ROT_AXIS, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
		send_cmd(aar_pkg::OP_ROT_AXIS, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		send_cmd(aar_pkg::OP_ROT_AXIS, 16'sd12868, 16'sh7fff, 16'sh8000, 16'sd4730, 1'b1);
		send_cmd(aar_pkg::OP_ROT_AXIS, 16'sd0, 16'sd4730, 16'sd4730, 16'sd4730, 1'b1);

		// random: blocks with and without gaps
		for (int n = 0; n < 450; n++) begin
			blk = n / 50;
			gaps = (blk % 3) != 1;
			send_cmd(2'($urandom_range(0, 3)), rand_field(), rand_field(), rand_field(),
				rand_field(), gaps);
		end
		start <= 1'b0;

		while (n_pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (n_errors == 0)
			$display("axis_angle_rotation_matrix_test: done, clean");
		else
			$display("axis_angle_rotation_matrix_test: done, errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/aar_pkg.sv
rtl/core/axis_angle_rotation_matrix.sv
dv/axis_angle_rotation_matrix_checker.sv
dv/axis_angle_rotation_matrix_test.sv
